// ----- rtl/core/qoi_legacy_chunk_decoder_defines.svh -----
// ----------------------------------------------------------------------------
// QOI legacy chunk decoder assertion macros
// Shared concurrent assertion forms for the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef QOI_LEGACY_CHUNK_DECODER_DEFINES_SVH
`define QOI_LEGACY_CHUNK_DECODER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define QLCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define QLCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/qlcd_pkg.sv -----
// ----------------------------------------------------------------------------
// QOI legacy chunk decoder package
// Payload types, job format between front and back, and fixed constants.
// ----------------------------------------------------------------------------
package qlcd_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int TABLE_AW      = 6;

    localparam logic [1:0] CMD_DATA  = 2'd0;
    localparam logic [1:0] CMD_END   = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    // BYTE: a data byte that does not complete a chunk
    typedef enum logic [1:0] {
        KIND_BYTE,
        KIND_CHUNK,
        KIND_END,
        KIND_START
    } t_kind;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [31:0] repeat_res;
        logic        image_done;
    } t_out_item;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  head;
        logic [31:0] tail;
    } t_job;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_pixel;

    localparam t_pixel PIXEL_RESET = '{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'd255};

endpackage

// ----- rtl/core/qlcd_stream_if.sv -----
// ----------------------------------------------------------------------------
// QOI legacy chunk decoder stream interface
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface qlcd_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/qoi_legacy_chunk_decoder.sv -----
// ----------------------------------------------------------------------------
// QOI legacy chunk decoder
// Decodes early-format QOI chunk bytes into pixels with repeat counts.
// ----------------------------------------------------------------------------
// Takes one command item per cycle: a chunk byte, end of data, or start of a
// new image. The front end gathers multi-byte chunks and queues one job per
// item; the back end reads the 64-entry colour table into a registered stage,
// from which it updates the pixel, writes the table and loads the output
// register. Sustained rate is one item per clock while results are taken; a
// held result stalls the back end and, once the QUEUE_DEPTH job queue fills,
// the input. A start item clears the table at once through per-entry valid
// bits, so there is no clearing pass. pixel_count is written through i_cfg_we
// and i_cfg_wdata; the user must write it only while the block is idle, as
// the block itself does not enforce this.
module qoi_legacy_chunk_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_wdata,
    qlcd_stream_if.sink   i_in,
    qlcd_stream_if.source o_out
);
    import qlcd_pkg::*;

    logic [31:0] r_pixel_count;
    logic        w_push;
    t_job        w_push_job;
    logic        w_full;
    logic        w_job_valid;
    t_job        w_job;
    logic        w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_count <= '0;
        end else if (i_cfg_we) begin
            r_pixel_count <= i_cfg_wdata;
        end
    end

    qlcd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_push_job)
    );

    qlcd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .o_valid (w_job_valid),
        .o_job   (w_job),
        .i_pop   (w_pop)
    );

    qlcd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pixel_count (r_pixel_count),
        .i_job_valid   (w_job_valid),
        .i_job         (w_job),
        .o_pop         (w_pop),
        .o_out         (o_out)
    );
endmodule

// ----- rtl/core/qlcd_ram.sv -----
// ----------------------------------------------------------------------------
// QOI legacy chunk decoder generic RAM
// One write port, one read port, registered read data (old data on collision).
// ----------------------------------------------------------------------------
module qlcd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ----- rtl/core/qlcd_front.sv -----
// ----------------------------------------------------------------------------
// QOI legacy chunk decoder front end
// Accepts command items, gathers chunk bytes and issues one job per start, end or data item.
// ----------------------------------------------------------------------------
module qlcd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    qlcd_stream_if.sink   i_in,
    input  logic          i_full,
    output logic          o_push,
    output qlcd_pkg::t_job o_job
);
    import qlcd_pkg::*;

    logic [7:0]  r_head, n_head;
    logic [31:0] r_tail, n_tail;
    logic [2:0]  r_pending, n_pending;
    logic        w_accept;
    logic [2:0]  w_extra;

    function automatic logic [2:0] extra_bytes(input logic [7:0] op);
        logic [2:0] n;
        n = 3'd0;
        priority if (op[7:6] == 2'b00) begin
            n = 3'd0;
        end else if (op[7:5] == 3'b010) begin
            n = 3'd0;
        end else if (op[7:5] == 3'b011) begin
            n = 3'd1;
        end else if (op[7:6] == 2'b10) begin
            n = 3'd0;
        end else if (op[7:5] == 3'b110) begin
            n = 3'd1;
        end else if (op[7:4] == 4'b1110) begin
            n = 3'd2;
        end else begin
            n = {2'b00, op[3]} + {2'b00, op[2]} + {2'b00, op[1]} + {2'b00, op[0]};
        end
        return n;
    endfunction

    assign i_in.ready = !i_full;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_extra    = extra_bytes(i_in.payload.data_byte);

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_pending = r_pending;
        o_push    = 1'b0;
        o_job     = '{kind: KIND_BYTE, head: r_head, tail: r_tail};
        if (w_accept) begin
            unique case (i_in.payload.cmd)
                CMD_START: begin
                    o_push     = 1'b1;
                    o_job.kind = KIND_START;
                    n_pending  = 3'd0;
                    n_tail     = '0;
                end
                CMD_END: begin
                    // drop any partial chunk
                    o_push     = 1'b1;
                    o_job.kind = KIND_END;
                    n_pending  = 3'd0;
                    n_tail     = '0;
                end
                CMD_DATA: begin
                    o_push = 1'b1;
                    if (r_pending == 3'd0) begin
                        n_head = i_in.payload.data_byte;
                        n_tail = '0;
                        if (w_extra == 3'd0) begin
                            o_job = '{kind: KIND_CHUNK, head: i_in.payload.data_byte,
                                      tail: 32'd0};
                        end else begin
                            n_pending = w_extra;
                        end
                    end else begin
                        n_tail    = {r_tail[23:0], i_in.payload.data_byte};
                        n_pending = r_pending - 3'd1;
                        if (r_pending == 3'd1) begin
                            o_job = '{kind: KIND_CHUNK, head: r_head, tail: n_tail};
                        end
                    end
                end
                default: begin
                    // unused command: no job
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 3'd0;
        end else begin
            r_pending <= n_pending;
        end
        r_head <= n_head;
        r_tail <= n_tail;
    end
endmodule

// ----- rtl/core/qlcd_fifo.sv -----
// ----------------------------------------------------------------------------
// QOI legacy chunk decoder job queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`include "qoi_legacy_chunk_decoder_defines.svh"

module qlcd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  qlcd_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_valid,
    output qlcd_pkg::t_job o_job,
    input  logic           i_pop
);
    import qlcd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    `QLCD_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, i_push, !o_full, "job pushed into full queue")
    `QLCD_ASSERT_NOW(a_no_underflow, i_clk, i_rst_n, i_pop, r_count != '0, "job popped from empty queue")
endmodule

// ----- rtl/core/qlcd_back.sv -----
// ----------------------------------------------------------------------------
// QOI legacy chunk decoder back end
// Reads the colour table, updates the pixel, stores it and emits results.
// ----------------------------------------------------------------------------
`include "qoi_legacy_chunk_decoder_defines.svh"

module qlcd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [31:0]    i_pixel_count,
    input  logic           i_job_valid,
    input  qlcd_pkg::t_job i_job,
    output logic           o_pop,
    qlcd_stream_if.source  o_out
);
    import qlcd_pkg::*;

    logic                     r_e2_valid, n_e2_valid;
    t_job                     r_e2_job;
    logic                     r_fwd_hit;
    logic [31:0]              r_fwd_data;
    t_pixel                   r_cur, n_cur;
    logic [TABLE_ENTRIES-1:0] r_tbl_valid, n_tbl_valid;
    logic [31:0]              r_emitted, n_emitted;
    logic                     r_finished, n_finished;
    logic                     r_out_valid, n_out_valid;
    t_out_item                r_out, n_result;

    logic                e2_fire;
    logic                w_done;
    logic [31:0]         w_rd_data;
    logic [31:0]         w_entry;
    t_pixel              w_pix;
    logic [31:0]         w_rep_req;
    logic [31:0]         w_rep;
    logic [31:0]         w_left;
    logic                w_emit;
    logic                w_wr_en;
    logic [TABLE_AW-1:0] w_slot;
    logic [2:0]          w_nflags;
    logic [2:0]          w_idx_r, w_idx_g, w_idx_b;
    logic [19:0]         w_m;

    function automatic logic [7:0] tail_byte(input logic [31:0] t, input logic [1:0] k);
        logic [7:0] b;
        unique case (k)
            2'd0: b = t[7:0];
            2'd1: b = t[15:8];
            2'd2: b = t[23:16];
            2'd3: b = t[31:24];
        endcase
        return b;
    endfunction

    assign e2_fire = r_e2_valid && (!r_out_valid || o_out.ready);
    assign o_pop   = i_job_valid && (!r_e2_valid || e2_fire);

    qlcd_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_slot),
        .i_wr_data (w_pix),
        .i_rd_en   (o_pop),
        .i_rd_addr (i_job.head[TABLE_AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    // table entry: a write at the read edge wins, an unwritten slot reads zero
    always_comb begin
        if (r_fwd_hit) begin
            w_entry = r_fwd_data;
        end else if (r_tbl_valid[r_e2_job.head[TABLE_AW-1:0]]) begin
            w_entry = w_rd_data;
        end else begin
            w_entry = '0;
        end
    end

    assign w_done   = r_finished || (r_emitted >= i_pixel_count);
    assign w_left   = i_pixel_count - r_emitted;
    assign w_nflags = {2'b00, r_e2_job.head[3]} + {2'b00, r_e2_job.head[2]}
                    + {2'b00, r_e2_job.head[1]} + {2'b00, r_e2_job.head[0]};
    assign w_idx_r  = w_nflags - 3'd1;
    assign w_idx_g  = w_idx_r - {2'b00, r_e2_job.head[3]};
    assign w_idx_b  = w_idx_g - {2'b00, r_e2_job.head[2]};
    assign w_m      = {r_e2_job.head[3:0], r_e2_job.tail[15:0]};

    // chunk decode on the current pixel
    always_comb begin
        logic [7:0] op;
        op        = r_e2_job.head;
        w_pix     = r_cur;
        w_rep_req = 32'd1;
        priority if (op[7:6] == 2'b00) begin
            w_pix = w_entry;
        end else if (op[7:5] == 3'b010) begin
            w_rep_req = {27'd0, op[4:0]} + 32'd1;
        end else if (op[7:5] == 3'b011) begin
            w_rep_req = {19'd0, op[4:0], r_e2_job.tail[7:0]} + 32'd33;
        end else if (op[7:6] == 2'b10) begin
            w_pix.red   = r_cur.red   + {{6{op[5]}}, op[5:4]};
            w_pix.green = r_cur.green + {{6{op[3]}}, op[3:2]};
            w_pix.blue  = r_cur.blue  + {{6{op[1]}}, op[1:0]};
        end else if (op[7:5] == 3'b110) begin
            w_pix.red   = r_cur.red   + {{3{op[4]}}, op[4:0]};
            w_pix.green = r_cur.green + {{4{r_e2_job.tail[7]}}, r_e2_job.tail[7:4]};
            w_pix.blue  = r_cur.blue  + {{4{r_e2_job.tail[3]}}, r_e2_job.tail[3:0]};
        end else if (op[7:4] == 4'b1110) begin
            w_pix.red   = r_cur.red   + {{3{w_m[19]}}, w_m[19:15]};
            w_pix.green = r_cur.green + {{3{w_m[14]}}, w_m[14:10]};
            w_pix.blue  = r_cur.blue  + {{3{w_m[9]}}, w_m[9:5]};
            w_pix.alpha = r_cur.alpha + {{3{w_m[4]}}, w_m[4:0]};
        end else begin
            // flagged channels take the received bytes in order, red first
            if (op[3]) begin
                w_pix.red = tail_byte(r_e2_job.tail, w_idx_r[1:0]);
            end
            if (op[2]) begin
                w_pix.green = tail_byte(r_e2_job.tail, w_idx_g[1:0]);
            end
            if (op[1]) begin
                w_pix.blue = tail_byte(r_e2_job.tail, w_idx_b[1:0]);
            end
            if (op[0]) begin
                w_pix.alpha = r_e2_job.tail[7:0];
            end
        end
    end

    assign w_slot = w_pix.red[TABLE_AW-1:0] ^ w_pix.green[TABLE_AW-1:0]
                  ^ w_pix.blue[TABLE_AW-1:0] ^ w_pix.alpha[TABLE_AW-1:0];
    assign w_wr_en = e2_fire && (r_e2_job.kind == KIND_CHUNK) && !w_done;

    always_comb begin
        n_cur       = r_cur;
        n_tbl_valid = r_tbl_valid;
        n_emitted   = r_emitted;
        n_finished  = r_finished;
        w_emit      = 1'b0;
        w_rep       = w_left;
        n_result    = '{red: r_cur.red, green: r_cur.green, blue: r_cur.blue,
                        alpha: r_cur.alpha, repeat_res: w_left, image_done: 1'b0};
        unique case (r_e2_job.kind)
            KIND_START: begin
                n_cur       = PIXEL_RESET;
                n_tbl_valid = '0;
                n_emitted   = '0;
                n_finished  = 1'b0;
            end
            KIND_BYTE: begin
                if (w_done) begin
                    n_finished = 1'b1;
                end
            end
            KIND_END: begin
                if (w_done) begin
                    n_finished = 1'b1;
                end else begin
                    w_emit = 1'b1;
                    w_rep  = w_left;
                end
            end
            KIND_CHUNK: begin
                if (w_done) begin
                    n_finished = 1'b1;
                end else begin
                    w_emit              = 1'b1;
                    w_rep               = (w_rep_req > w_left) ? w_left : w_rep_req;
                    n_cur               = w_pix;
                    n_tbl_valid[w_slot] = 1'b1;
                    n_result.red        = w_pix.red;
                    n_result.green      = w_pix.green;
                    n_result.blue       = w_pix.blue;
                    n_result.alpha      = w_pix.alpha;
                end
            end
        endcase
        if (w_emit) begin
            n_emitted           = r_emitted + w_rep;
            n_result.repeat_res = w_rep;
            n_result.image_done = (n_emitted == i_pixel_count);
            if (n_emitted == i_pixel_count) begin
                n_finished = 1'b1;
            end
        end
    end

    assign n_e2_valid  = o_pop ? 1'b1 : (e2_fire ? 1'b0 : r_e2_valid);
    assign n_out_valid = e2_fire ? w_emit : (r_out_valid && !o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd_hit   <= 1'b0;
            r_cur       <= PIXEL_RESET;
            r_tbl_valid <= '0;
            r_emitted   <= '0;
            r_finished  <= 1'b0;
        end else begin
            r_e2_valid  <= n_e2_valid;
            r_out_valid <= n_out_valid;
            if (o_pop) begin
                r_fwd_hit <= w_wr_en && (w_slot == i_job.head[TABLE_AW-1:0]);
            end
            if (e2_fire) begin
                r_cur       <= n_cur;
                r_tbl_valid <= n_tbl_valid;
                r_emitted   <= n_emitted;
                r_finished  <= n_finished;
            end
        end
        if (o_pop) begin
            r_e2_job   <= i_job;
            r_fwd_data <= w_pix;
        end
        if (e2_fire && w_emit) begin
            r_out <= n_result;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    `QLCD_ASSERT_NOW(a_repeat_nonzero, i_clk, i_rst_n, r_out_valid, r_out.repeat_res != '0, "result with zero repeat")
    `QLCD_ASSERT_NEXT(a_done_sets_finished, i_clk, i_rst_n, e2_fire && w_emit && n_result.image_done, r_finished, "image done without finished flag")
    `QLCD_ASSERT_NEXT(a_start_clears, i_clk, i_rst_n, e2_fire && (r_e2_job.kind == KIND_START), (r_emitted == '0) && !r_finished, "start did not clear counters")
endmodule
